[src/ccpe_pkg.sv]
// Package: widths, types and constants shared by the cubic curve point evaluator.
package ccpe_pkg;

   localparam int FRAC_BITS = 16;
   localparam int T_W       = FRAC_BITS + 1;
   localparam int CW        = 32;
   localparam int VW        = CW + 6;
   localparam int PW        = VW + T_W + 1;

   localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic KIND_BEZIER  = 1'b0;
   localparam logic KIND_CATMULL = 1'b1;

   localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [VW-1:0] val_type;
   typedef logic [T_W-1:0]       tpar_type;

   typedef struct packed {
      logic     kind;
      tpar_type t;
      val_type  c2;
      val_type  d2;
   } side_type;

endpackage

[src/ccpe_if.sv]
// Request and response channel interfaces.
interface ccpe_req_if;
   import ccpe_pkg::*;
   logic      valid;
   logic      ready;
   logic      kind;
   tpar_type  t_param;
   coord_type p_start;
   coord_type p_ctrl_one;
   coord_type p_ctrl_two;
   coord_type p_end;

   modport source (output valid, kind, t_param, p_start, p_ctrl_one, p_ctrl_two, p_end,
                   input ready);
   modport sink   (input valid, kind, t_param, p_start, p_ctrl_one, p_ctrl_two, p_end,
                   output ready);
endinterface

interface ccpe_rsp_if;
   import ccpe_pkg::*;
   logic      valid;
   logic      ready;
   coord_type point_coord;
   logic      saturated;

   modport source (output valid, point_coord, saturated, input ready);
   modport sink   (input valid, point_coord, saturated, output ready);
endinterface

[src/ccpe_mac_lane.sv]
// Two-stage multiply by t, round half up, and add lane.
module ccpe_mac_lane (
   input  logic               clock,
   input  logic               en,
   input  ccpe_pkg::tpar_type t,
   input  ccpe_pkg::val_type  x,
   input  ccpe_pkg::val_type  addend,
   output ccpe_pkg::val_type  result
);
   import ccpe_pkg::*;

   localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

   logic signed [PW-1:0] prod_in, prod_ff;
   val_type              addend_ff;
   logic signed [PW-1:0] rnd;
   logic signed [PW-1:0] shifted;
   val_type              result_in, result_ff;

   assign prod_in   = PW'(x) * PW'($signed({1'b0, t}));
   assign rnd       = prod_ff + HALF;
   assign shifted   = rnd >>> FRAC_BITS;
   assign result_in = addend_ff + $signed(shifted[VW-1:0]);
   assign result    = result_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         addend_ff <= addend;
         result_ff <= result_in;
      end
   end

endmodule

[src/cubic_curve_point_evaluator_core.sv]
// Cubic Bezier / Catmull-Rom point evaluator, one axis per request, fully pipelined.
// Accepts one request per cycle while the pipe is not held. Its point is registered in
// point_ff and driven on rsp_bus, with valid taken from the last stage's valid bit.
// Bezier requests run de Casteljau's three interpolation levels; Catmull-Rom requests
// reuse lane 0 of each level for one Horner step of the doubled coefficients. Each
// level is a prep stage plus a two-stage multiply/round/add lane. The whole pipe
// holds when the response register is full and rsp_bus.ready is low, so req_bus.ready
// follows rsp_bus.ready in that case. Results outside the signed 32-bit range are
// clamped and flagged by saturated; t above 1.0 is treated as 1.0.
module cubic_curve_point_evaluator_core (
   input logic clock,
   input logic reset,
   ccpe_req_if.sink   req_bus,
   ccpe_rsp_if.source rsp_bus
);
   import ccpe_pkg::*;

   localparam int NSTG = 12;

   logic            adv;
   logic [NSTG-1:0] vld_ff, vld_in;

   // stage 0
   tpar_type  t_clamp;
   logic      kind0_ff;
   tpar_type  t0_ff;
   coord_type pa0_ff, pb0_ff, pc0_ff, pd0_ff;

   // stage 1
   logic      kind1_ff;
   tpar_type  t1_ff;
   val_type   a1_ff, b1_ff, c1_ff;
   val_type   dab1_ff, dbc1_ff, dcd1_ff, dda1_ff;

   // side band through levels, stages 2..10
   side_type  side_ff [2:10];
   side_type  side2_in;

   val_type   x2_ff [3], ad2_ff [3], x2_in [3], ad2_in [3];
   val_type   lv1 [3];
   val_type   x5_ff [2], ad5_ff [2], x5_in [2], ad5_in [2];
   val_type   lv2 [2];
   val_type   x8_ff, ad8_ff, x8_in, ad8_in;
   val_type   lv3;

   val_type   fin;
   logic      ovf;
   coord_type point_in, point_ff;
   logic      sat_ff;

   assign adv           = !(vld_ff[NSTG-1] && !rsp_bus.ready);
   assign req_bus.ready = adv;
   assign vld_in        = {vld_ff[NSTG-2:0], req_bus.valid};
   assign t_clamp       = (req_bus.t_param > T_ONE) ? T_ONE : req_bus.t_param;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // level 1 operands: Bezier differences, Catmull-Rom doubled coefficients
   always_comb begin
      x2_in[0]      = dab1_ff;
      x2_in[1]      = dbc1_ff;
      x2_in[2]      = dcd1_ff;
      ad2_in[0]     = a1_ff;
      ad2_in[1]     = b1_ff;
      ad2_in[2]     = c1_ff;
      side2_in.kind = kind1_ff;
      side2_in.t    = t1_ff;
      side2_in.c2   = dab1_ff + dbc1_ff;
      side2_in.d2   = b1_ff <<< 1;
      if (kind1_ff == KIND_CATMULL) begin
         x2_in[0]  = dda1_ff - (dbc1_ff <<< 1) - dbc1_ff;
         ad2_in[0] = (dbc1_ff <<< 1) + dbc1_ff - (dab1_ff <<< 1) - dcd1_ff;
      end
   end

   // level 2 operands
   always_comb begin
      x5_in[0]  = lv1[1] - lv1[0];
      x5_in[1]  = lv1[2] - lv1[1];
      ad5_in[0] = lv1[0];
      ad5_in[1] = lv1[1];
      if (side_ff[4].kind == KIND_CATMULL) begin
         x5_in[0]  = lv1[0];
         ad5_in[0] = side_ff[4].c2;
      end
   end

   // level 3 operands
   always_comb begin
      x8_in  = lv2[1] - lv2[0];
      ad8_in = lv2[0];
      if (side_ff[7].kind == KIND_CATMULL) begin
         x8_in  = lv2[0];
         ad8_in = side_ff[7].d2;
      end
   end

   // halve Catmull-Rom result, then clamp to 32 bits
   always_comb begin
      fin      = (side_ff[10].kind == KIND_CATMULL) ? ((lv3 + val_type'(1)) >>> 1) : lv3;
      ovf      = !((&fin[VW-1:CW-1]) || !(|fin[VW-1:CW-1]));
      point_in = fin[CW-1:0];
      if (ovf) begin
         point_in = fin[VW-1] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind0_ff <= req_bus.kind;
         t0_ff    <= t_clamp;
         pa0_ff   <= req_bus.p_start;
         pb0_ff   <= req_bus.p_ctrl_one;
         pc0_ff   <= req_bus.p_ctrl_two;
         pd0_ff   <= req_bus.p_end;

         kind1_ff <= kind0_ff;
         t1_ff    <= t0_ff;
         a1_ff    <= val_type'(pa0_ff);
         b1_ff    <= val_type'(pb0_ff);
         c1_ff    <= val_type'(pc0_ff);
         dab1_ff  <= val_type'(pb0_ff) - val_type'(pa0_ff);
         dbc1_ff  <= val_type'(pc0_ff) - val_type'(pb0_ff);
         dcd1_ff  <= val_type'(pd0_ff) - val_type'(pc0_ff);
         dda1_ff  <= val_type'(pd0_ff) - val_type'(pa0_ff);

         side_ff[2] <= side2_in;
         for (int i = 3; i <= 10; i++) begin
            side_ff[i] <= side_ff[i-1];
         end

         x2_ff  <= x2_in;
         ad2_ff <= ad2_in;
         x5_ff  <= x5_in;
         ad5_ff <= ad5_in;
         x8_ff  <= x8_in;
         ad8_ff <= ad8_in;

         point_ff <= point_in;
         sat_ff   <= ovf;
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lvl1
      ccpe_mac_lane u_lane (
         .clock  (clock),
         .en     (adv),
         .t      (side_ff[2].t),
         .x      (x2_ff[g]),
         .addend (ad2_ff[g]),
         .result (lv1[g])
      );
   end

   for (genvar g = 0; g < 2; g++) begin : g_lvl2
      ccpe_mac_lane u_lane (
         .clock  (clock),
         .en     (adv),
         .t      (side_ff[5].t),
         .x      (x5_ff[g]),
         .addend (ad5_ff[g]),
         .result (lv2[g])
      );
   end

   ccpe_mac_lane u_lvl3 (
      .clock  (clock),
      .en     (adv),
      .t      (side_ff[8].t),
      .x      (x8_ff),
      .addend (ad8_ff),
      .result (lv3)
   );

   assign rsp_bus.valid       = vld_ff[NSTG-1];
   assign rsp_bus.point_coord = point_ff;
   assign rsp_bus.saturated   = sat_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during stall");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> vld_ff[0])
      else $error("accepted request missing from stage 0");

   a_bezier_no_sat: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[10] && side_ff[10].kind == KIND_BEZIER) |-> !ovf)
      else $error("Bezier result out of range");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !vld_ff[10]) |=> !rsp_bus.valid)
      else $error("response repeated after delivery");

endmodule
